[hdl/longest_chain_forest_update_defines.svh]
// Assertion macros for longest_chain_forest_update.sv.
`ifndef LONGEST_CHAIN_FOREST_UPDATE_DEFINES_SVH
`define LONGEST_CHAIN_FOREST_UPDATE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define LCF_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lcf assertion failed");

// Checks an implication that must hold even while reset is active.
`define LCF_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("lcf assertion failed");

`endif

[hdl/lcf_pkg.sv]
package lcf_pkg;

   // Node indexing and table depth.
   localparam int NODE_COUNT = 256;
   localparam int NODE_W = 8;
   localparam int STEP_W = 9;

   // Result outcome codes.
   localparam logic [2:0] OUT_LINKED    = 3'd0;
   localparam logic [2:0] OUT_LOOP      = 3'd1;
   localparam logic [2:0] OUT_SAME      = 3'd2;
   localparam logic [2:0] OUT_RELINKED  = 3'd3;
   localparam logic [2:0] OUT_NO_COMMON = 3'd4;
   localparam logic [2:0] OUT_NOT_LONG  = 3'd5;
   localparam logic [2:0] OUT_READ      = 3'd6;

   // Command codes.
   localparam logic CMD_LINK = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef logic [NODE_W-1:0] node_type;

   // One parent table entry.
   typedef struct packed {
      logic     valid;
      node_type parent;
   } entry_type;

endpackage

[hdl/lcf_if.sv]
// Request channel: one link or read command.
interface lcf_req_if import lcf_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     cmd;
   node_type source_node;
   node_type target_node;

   modport source(output valid, output cmd, output source_node, output target_node,
                  input ready);
   modport sink(input valid, input cmd, input source_node, input target_node,
                output ready);
endinterface

// Response channel: one result per request.
interface lcf_rsp_if import lcf_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] outcome;
   logic       has_parent;
   node_type   parent_node;

   modport source(output valid, output outcome, output has_parent, output parent_node,
                  input ready);
   modport sink(input valid, input outcome, input has_parent, input parent_node,
                output ready);
endinterface

[hdl/longest_chain_forest_update.sv]
// Longest-chain forest update.
// Requests arrive on req (valid/ready); each carries cmd, source_node and
// target_node. A read returns the parent of source_node; a link offers the
// edge source -> target and replaces an existing parent only when the new
// path to the first common ancestor is strictly longer.
// Every request yields exactly one transfer on rsp with outcome, has_parent
// and parent_node. One request is processed at a time.
// A read or an unchanged parent finishes without a walk. A link walks
// ancestor chains through the parent memory, one node per cycle: loop check,
// marking of the old chain, the new chain, unmarking and the old length.
// After reset the block sweeps all 256 entries of the parent and mark memories,
// one entry per cycle, with req.ready low.
// A finished result sits in the rsp output register; if the receiver stalls,
// the next result waits in the block until the register is free.
`include "longest_chain_forest_update_defines.svh"
module longest_chain_forest_update import lcf_pkg::*; (
   input logic        clock,
   input logic        reset,
   lcf_req_if.sink    req,
   lcf_rsp_if.source  rsp
);

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_HEAD   = 4'd2;
   localparam logic [3:0] S_LOOP   = 4'd3;
   localparam logic [3:0] S_MARK   = 4'd4;
   localparam logic [3:0] S_NSTART = 4'd5;
   localparam logic [3:0] S_NEW    = 4'd6;
   localparam logic [3:0] S_OLD    = 4'd7;
   localparam logic [3:0] S_CMP    = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(NODE_COUNT);

   // Memories with registered read data.
   entry_type ptab_mem [NODE_COUNT];
   logic      mark_mem [NODE_COUNT];
   entry_type prd_ff;
   logic      mrd_ff;

   logic [3:0]        state_ff, state_in;
   logic [STEP_W-1:0] clr_ff, clr_in;
   logic              cmd_ff, cmd_in;
   node_type          src_ff, src_in, tgt_ff, tgt_in;
   logic              sv_ff, sv_in;
   node_type          sp_ff, sp_in;
   node_type          w_ff, w_in;
   logic [STEP_W-1:0] n_ff, n_in;
   logic [STEP_W-1:0] nlen_ff, nlen_in, olen_ff, olen_in;
   logic              setm_ff, setm_in;
   logic              found_ff, found_in;
   node_type          com_ff, com_in;
   logic [2:0]        res_out_ff, res_out_in;
   logic              res_has_ff, res_has_in;
   node_type          res_par_ff, res_par_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_out_ff, rsp_out_in;
   logic              rsp_has_ff, rsp_has_in;
   node_type          rsp_par_ff, rsp_par_in;

   node_type  rd_addr;
   logic      pw_en, mw_en, mw_data;
   node_type  pw_addr, mw_addr;
   entry_type pw_data;

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.outcome     = rsp_out_ff;
   assign rsp.has_parent  = rsp_has_ff;
   assign rsp.parent_node = rsp_par_ff;

   // Next-state logic of the chain-walking sequencer.
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      cmd_in     = cmd_ff;
      src_in     = src_ff;
      tgt_in     = tgt_ff;
      sv_in      = sv_ff;
      sp_in      = sp_ff;
      w_in       = w_ff;
      n_in       = n_ff;
      nlen_in    = nlen_ff;
      olen_in    = olen_ff;
      setm_in    = setm_ff;
      found_in   = found_ff;
      com_in     = com_ff;
      res_out_in = res_out_ff;
      res_has_in = res_has_ff;
      res_par_in = res_par_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_out_in = rsp_out_ff;
      rsp_has_in = rsp_has_ff;
      rsp_par_in = rsp_par_ff;
      rd_addr    = w_ff;
      pw_en      = 1'b0;
      pw_addr    = src_ff;
      pw_data    = '{valid: 1'b1, parent: tgt_ff};
      mw_en      = 1'b0;
      mw_addr    = w_ff;
      mw_data    = setm_ff;
      case (state_ff)
         S_CLR: begin
            pw_en   = 1'b1;
            pw_addr = clr_ff[NODE_W-1:0];
            pw_data = '0;
            mw_en   = 1'b1;
            mw_addr = clr_ff[NODE_W-1:0];
            mw_data = 1'b0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == STEP_LIMIT - 1'b1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rd_addr = req.source_node;
            if (req.valid) begin
               cmd_in   = req.cmd;
               src_in   = req.source_node;
               tgt_in   = req.target_node;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            // Entry of the source is available; choose the path.
            sv_in      = prd_ff.valid;
            sp_in      = prd_ff.parent;
            res_has_in = prd_ff.valid;
            res_par_in = prd_ff.valid ? prd_ff.parent : '0;
            rd_addr    = tgt_ff;
            w_in       = tgt_ff;
            n_in       = '0;
            if (cmd_ff == CMD_READ) begin
               res_out_in = OUT_READ;
               state_in   = S_DONE;
            end else if (prd_ff.valid && prd_ff.parent == tgt_ff) begin
               res_out_in = OUT_SAME;
               state_in   = S_DONE;
            end else begin
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            // Does the chain from the target reach the source?
            if (n_ff != STEP_LIMIT && w_ff == src_ff) begin
               res_out_in = OUT_LOOP;
               state_in   = S_DONE;
            end else if (n_ff == STEP_LIMIT || !prd_ff.valid) begin
               if (!sv_ff) begin
                  pw_en      = 1'b1;
                  res_out_in = OUT_LINKED;
                  res_has_in = 1'b1;
                  res_par_in = tgt_ff;
                  state_in   = S_DONE;
               end else begin
                  w_in     = sp_ff;
                  rd_addr  = sp_ff;
                  n_in     = '0;
                  setm_in  = 1'b1;
                  state_in = S_MARK;
               end
            end else begin
               w_in    = prd_ff.parent;
               rd_addr = prd_ff.parent;
               n_in    = n_ff + 1'b1;
            end
         end
         S_MARK: begin
            // Set or clear the mark of every node on the old chain.
            if (n_ff == STEP_LIMIT) begin
               state_in = setm_ff ? S_NSTART : S_OLD;
            end else begin
               mw_en = 1'b1;
               if (!prd_ff.valid) begin
                  state_in = setm_ff ? S_NSTART : S_OLD;
               end else begin
                  w_in    = prd_ff.parent;
                  rd_addr = prd_ff.parent;
                  n_in    = n_ff + 1'b1;
               end
            end
            if (state_in == S_OLD) begin
               if (!found_ff) begin
                  res_out_in = OUT_NO_COMMON;
                  state_in   = S_DONE;
               end else begin
                  w_in    = src_ff;
                  rd_addr = src_ff;
                  n_in    = '0;
                  olen_in = '0;
               end
            end
         end
         S_NSTART: begin
            w_in     = tgt_ff;
            rd_addr  = tgt_ff;
            n_in     = '0;
            nlen_in  = '0;
            state_in = S_NEW;
         end
         S_NEW: begin
            // Walk from the target to the first marked node or the end of its chain.
            if (n_ff == STEP_LIMIT) begin
               found_in = 1'b0;
               com_in   = w_ff;
               state_in = S_MARK;
            end else begin
               nlen_in = nlen_ff + 1'b1;
               if (mrd_ff || !prd_ff.valid) begin
                  found_in = mrd_ff;
                  com_in   = w_ff;
                  state_in = S_MARK;
               end else begin
                  w_in    = prd_ff.parent;
                  rd_addr = prd_ff.parent;
                  n_in    = n_ff + 1'b1;
               end
            end
            if (state_in == S_MARK) begin
               w_in    = sp_ff;
               rd_addr = sp_ff;
               n_in    = '0;
               setm_in = 1'b0;
            end
         end
         S_OLD: begin
            // Length of the old path from the source to the common node.
            if (n_ff == STEP_LIMIT || w_ff == com_ff) begin
               state_in = S_CMP;
            end else begin
               olen_in = olen_ff + 1'b1;
               if (!prd_ff.valid) begin
                  state_in = S_CMP;
               end else begin
                  w_in    = prd_ff.parent;
                  rd_addr = prd_ff.parent;
                  n_in    = n_ff + 1'b1;
               end
            end
         end
         S_CMP: begin
            if (nlen_ff > olen_ff) begin
               pw_en      = 1'b1;
               res_out_in = OUT_RELINKED;
               res_par_in = tgt_ff;
            end else begin
               res_out_in = OUT_NOT_LONG;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_out_in   = res_out_ff;
               rsp_has_in   = res_has_ff;
               rsp_par_in   = res_par_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Parent and mark memories.
   always_ff @(posedge clock) begin
      if (pw_en) begin
         ptab_mem[pw_addr] <= pw_data;
      end
      if (mw_en) begin
         mark_mem[mw_addr] <= mw_data;
      end
      prd_ff <= ptab_mem[rd_addr];
      mrd_ff <= mark_mem[rd_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      src_ff     <= src_in;
      tgt_ff     <= tgt_in;
      sv_ff      <= sv_in;
      sp_ff      <= sp_in;
      w_ff       <= w_in;
      n_ff       <= n_in;
      nlen_ff    <= nlen_in;
      olen_ff    <= olen_in;
      setm_ff    <= setm_in;
      found_ff   <= found_in;
      com_ff     <= com_in;
      res_out_ff <= res_out_in;
      res_has_ff <= res_has_in;
      res_par_ff <= res_par_in;
      rsp_out_ff <= rsp_out_in;
      rsp_has_ff <= rsp_has_in;
      rsp_par_ff <= rsp_par_in;
   end

   // The step counter is only meaningful once a walk has been set up.
   `LCF_ASSERT_ALWAYS(a_clear_after_reset, reset |=> state_ff == S_CLR)
   `LCF_ASSERT(a_no_rsp_in_sweep, (state_ff == S_CLR) |-> !rsp_valid_ff)
   `LCF_ASSERT(a_walk_bound, (state_ff > S_HEAD) |-> n_ff <= STEP_LIMIT)
   `LCF_ASSERT(a_done_leads_out, (state_ff == S_DONE && !rsp_valid_ff) |=> rsp_valid_ff)

endmodule
